### hdl/mbrs_pkg.sv
package mbrs_pkg;

  localparam int RxBufferBytes    = 64;
  localparam int RegisterCount    = 64;
  localparam int MaxReadRegisters = 29;

  localparam int RxAw  = $clog2(RxBufferBytes);
  localparam int RegAw = $clog2(RegisterCount);

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [7:0] GapTicksReset     = 8'd5;
  localparam logic [7:0] SlaveAddressReset = 8'd1;

  localparam logic [7:0] FnReadHolding = 8'd3;
  localparam logic [7:0] FnWriteSingle = 8'd6;

  localparam logic [RxAw-1:0] RequestBytes = RxAw'(8);

  typedef enum logic [1:0] {
    CFG_SLAVE_ENABLE  = 2'd0,
    CFG_SLAVE_ADDRESS = 2'd1,
    CFG_GAP_TICKS     = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_ECHO,
    ST_HDR,
    ST_RD_WAIT,
    ST_RD_HI,
    ST_RD_LO,
    ST_CRC_LO,
    ST_CRC_HI
  } state_t;

  typedef enum logic [2:0] {
    SEL_ECHO,
    SEL_QTY2,
    SEL_HI,
    SEL_LO,
    SEL_CRC_LO,
    SEL_CRC_HI
  } sel_t;

  typedef struct packed {
    logic take;
    logic clr_cnt;
    logic inc_cnt;
    logic shift_in;
    logic crc_rx_upd;
    logic crc_tx_init;
    logic hold_write;
    logic ptr_load;
    logic ptr_inc;
    logic send;
    logic send_last;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic       go;
    logic       do_read;
    logic       do_write;
    logic       out_free;
    logic       last_word;
    logic [3:0] cnt;
  } status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hdl/mbrs_ctrl.sv
module mbrs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mbrs_pkg::status_t status,
  output mbrs_pkg::cmd_t    cmd
);
  import mbrs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.sel = SEL_ECHO;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && status.go) begin
          cmd.clr_cnt = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.inc_cnt = 1'b1;
        cmd.shift_in = (status.cnt != 4'd0);
        cmd.crc_rx_upd = (status.cnt != 4'd0) && (status.cnt <= 4'd6);
        if (status.cnt == 4'd8) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.clr_cnt = 1'b1;
        if (status.do_write) begin
          cmd.hold_write = 1'b1;
          state_next = ST_ECHO;
        end else if (status.do_read) begin
          cmd.crc_tx_init = 1'b1;
          cmd.ptr_load = 1'b1;
          state_next = ST_HDR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ECHO: begin
        cmd.sel = SEL_ECHO;
        if (status.out_free) begin
          cmd.send = 1'b1;
          cmd.inc_cnt = 1'b1;
          if (status.cnt == 4'd7) begin
            cmd.send_last = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_HDR: begin
        cmd.sel = (status.cnt == 4'd2) ? SEL_QTY2 : SEL_ECHO;
        if (status.out_free) begin
          cmd.send = 1'b1;
          cmd.inc_cnt = 1'b1;
          if (status.cnt == 4'd2) begin
            state_next = ST_RD_WAIT;
          end
        end
      end
      ST_RD_WAIT: begin
        state_next = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd.sel = SEL_HI;
        if (status.out_free) begin
          cmd.send = 1'b1;
          state_next = ST_RD_LO;
        end
      end
      ST_RD_LO: begin
        cmd.sel = SEL_LO;
        if (status.out_free) begin
          cmd.send = 1'b1;
          cmd.ptr_inc = 1'b1;
          state_next = status.last_word ? ST_CRC_LO : ST_RD_WAIT;
        end
      end
      ST_CRC_LO: begin
        cmd.sel = SEL_CRC_LO;
        if (status.out_free) begin
          cmd.send = 1'b1;
          state_next = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        cmd.sel = SEL_CRC_HI;
        if (status.out_free) begin
          cmd.send = 1'b1;
          cmd.send_last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_send_free: assert property (@(posedge clk) disable iff (rst)
    cmd.send |-> status.out_free) else $error("send into a full output register");
  a_write_echo: assert property (@(posedge clk) disable iff (rst)
    cmd.hold_write |=> state == ST_ECHO) else $error("register write not followed by echo");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd.take) else $error("input taken while busy");
  a_load_check: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && status.cnt == 4'd8) |=> state == ST_CHECK)
    else $error("load did not end in check");

endmodule

### hdl/mbrs_dp.sv
module mbrs_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             kind,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       tx_byte,
  output logic             last,
  input  mbrs_pkg::cmd_t    cmd,
  output mbrs_pkg::status_t status
);
  import mbrs_pkg::*;

  logic             slave_enable;
  logic [7:0]       slave_address;
  logic [7:0]       gap_ticks;
  logic [RxAw-1:0]  byte_count;
  logic [7:0]       idle_counter;
  logic             receiving;
  logic [7:0]       fbuf [RxBufferBytes];
  logic [7:0]       rd;
  logic [7:0]       f [8];
  logic [3:0]       cnt;
  logic [15:0]      crc_rx;
  logic [15:0]      crc_tx;
  logic [15:0]      hmem [RegisterCount];
  logic [RegisterCount-1:0] hvalid;
  logic [15:0]      hold_q;
  logic             hold_v;
  logic [RegAw-1:0] ptr;
  logic [4:0]       words_left;
  logic [15:0]      start;
  logic [15:0]      qty;
  logic [16:0]      span;
  logic [15:0]      word;
  logic [7:0]       send_byte;
  logic             complete;
  logic             crc_ok;

  assign start = {f[2], f[3]};
  assign qty   = {f[4], f[5]};
  assign span  = {1'b0, start} + {1'b0, qty};
  assign word  = hold_v ? hold_q : 16'h0000;
  assign crc_ok = (crc_rx == {f[7], f[6]}) && (f[0] == slave_address);

  assign complete = cmd.take && kind && receiving && (idle_counter >= gap_ticks);

  assign status.go        = complete && slave_enable && (byte_count == RequestBytes);
  assign status.do_write  = crc_ok && (f[1] == FnWriteSingle) && (start < 16'(RegisterCount));
  assign status.do_read   = crc_ok && (f[1] == FnReadHolding) && (qty != 16'd0)
                            && (qty <= 16'(MaxReadRegisters)) && (span <= 17'(RegisterCount));
  assign status.out_free  = !out_valid || !out_stall;
  assign status.last_word = (words_left == 5'd1);
  assign status.cnt       = cnt;

  always_comb begin
    case (cmd.sel)
      SEL_ECHO:   send_byte = f[cnt[2:0]];
      SEL_QTY2:   send_byte = {qty[6:0], 1'b0};
      SEL_HI:     send_byte = word[15:8];
      SEL_LO:     send_byte = word[7:0];
      SEL_CRC_LO: send_byte = crc_tx[7:0];
      SEL_CRC_HI: send_byte = crc_tx[15:8];
      default:    send_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_enable  <= 1'b1;
      slave_address <= SlaveAddressReset;
      gap_ticks     <= GapTicksReset;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_SLAVE_ENABLE:  slave_enable  <= cfg_data[0];
        CFG_SLAVE_ADDRESS: slave_address <= cfg_data;
        CFG_GAP_TICKS:     gap_ticks     <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      idle_counter <= '0;
      receiving    <= 1'b0;
    end else if (cmd.take) begin
      if (!kind) begin
        byte_count   <= byte_count + RxAw'(1);
        idle_counter <= '0;
        receiving    <= 1'b1;
      end else if (complete) begin
        byte_count   <= '0;
        idle_counter <= '0;
        receiving    <= 1'b0;
      end else if (receiving) begin
        idle_counter <= idle_counter + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && !kind) begin
      fbuf[byte_count] <= rx_byte;
    end
    rd <= fbuf[RxAw'(cnt[2:0])];
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      for (int i = 0; i < 7; i++) begin
        f[i] <= f[i+1];
      end
      f[7] <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr_cnt) begin
      cnt <= '0;
    end else if (cmd.inc_cnt) begin
      cnt <= cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (status.go) begin
      crc_rx <= CrcInit;
    end else if (cmd.crc_rx_upd) begin
      crc_rx <= crc_byte(crc_rx, rd);
    end
    if (cmd.crc_tx_init) begin
      crc_tx <= CrcInit;
    end else if (cmd.send && cmd.sel != SEL_CRC_LO && cmd.sel != SEL_CRC_HI) begin
      crc_tx <= crc_byte(crc_tx, send_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_write) begin
      hmem[start[RegAw-1:0]] <= qty;
    end
    hold_q <= hmem[ptr];
    hold_v <= hvalid[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
    end else if (cmd.hold_write) begin
      hvalid[start[RegAw-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_load) begin
      ptr        <= start[RegAw-1:0];
      words_left <= qty[4:0];
    end else if (cmd.ptr_inc) begin
      ptr        <= ptr + RegAw'(1);
      words_left <= words_left - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.send) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      tx_byte <= send_byte;
      last    <= cmd.send_last;
    end
  end

endmodule

### hdl/modbus_rtu_slave_frame_engine.sv
// a received byte or a non-completing tick is taken in idle; in_stall stays low in idle
// a completing tick (8 bytes, enabled) loads the request, checks it, replies if valid
// write reply: 8 bytes at one per cycle while not stalled; read reply: 3 header
// bytes, per word a holding register read-port wait then high/low bytes, 2 crc bytes
// synchronous active-high reset: config to defaults, receive state cleared,
// holding registers read as zero until written
module modbus_rtu_slave_frame_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last
);
  import mbrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  mbrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mbrs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kind      (kind),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .last      (last),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
